/* rtl/mpd_pkg.sv */
// Package for the Morse pulse decoder: defaults, register indexes and the character table.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

  localparam int unsigned MaxMarksDef  = 5;
  localparam int unsigned CountBitsDef = 16;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CharW   = 7;
  localparam int unsigned MarkCntW = 3;
  localparam int unsigned PatW    = 5;
  localparam int unsigned TableLen = 36;

  localparam logic [CfgIdxW-1:0] CfgGapTimeout   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgShortLimit   = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgLongLimit    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgFirstMarkSwap = 4'd3;

  localparam logic [CfgW-1:0] GapTimeoutRst = 16'd450;
  localparam logic [CfgW-1:0] ShortLimitRst = 16'd100;
  localparam logic [CfgW-1:0] LongLimitRst  = 16'd200;
  localparam logic            FirstSwapRst  = 1'b1;

  localparam logic [CharW-1:0] CharSpace = 7'd32;

  // One table entry: number of marks, dash pattern (bit i set when mark i is a dash), ASCII code.
  typedef struct packed {
    logic [MarkCntW-1:0] len;
    logic [PatW-1:0]     pat;
    logic [CharW-1:0]    chr;
  } morse_entry_t;

  localparam morse_entry_t MorseTable [TableLen] = '{
    '{3'd2, 5'd2,  7'd65}, '{3'd4, 5'd1,  7'd66}, '{3'd4, 5'd5,  7'd67},
    '{3'd3, 5'd1,  7'd68}, '{3'd1, 5'd0,  7'd69}, '{3'd4, 5'd4,  7'd70},
    '{3'd3, 5'd3,  7'd71}, '{3'd4, 5'd0,  7'd72}, '{3'd2, 5'd0,  7'd73},
    '{3'd4, 5'd14, 7'd74}, '{3'd3, 5'd5,  7'd75}, '{3'd4, 5'd2,  7'd76},
    '{3'd2, 5'd3,  7'd77}, '{3'd2, 5'd1,  7'd78}, '{3'd3, 5'd7,  7'd79},
    '{3'd4, 5'd6,  7'd80}, '{3'd4, 5'd11, 7'd81}, '{3'd3, 5'd2,  7'd82},
    '{3'd3, 5'd0,  7'd83}, '{3'd1, 5'd1,  7'd84}, '{3'd3, 5'd4,  7'd85},
    '{3'd4, 5'd8,  7'd86}, '{3'd3, 5'd6,  7'd87}, '{3'd4, 5'd9,  7'd88},
    '{3'd4, 5'd13, 7'd89}, '{3'd4, 5'd3,  7'd90},
    '{3'd5, 5'd31, 7'd48}, '{3'd5, 5'd30, 7'd49}, '{3'd5, 5'd28, 7'd50},
    '{3'd5, 5'd24, 7'd51}, '{3'd5, 5'd16, 7'd52}, '{3'd5, 5'd0,  7'd53},
    '{3'd5, 5'd1,  7'd54}, '{3'd5, 5'd3,  7'd55}, '{3'd5, 5'd7,  7'd56},
    '{3'd5, 5'd15, 7'd57}
  };

  // Returns the ASCII code for a stored mark sequence, or a space when nothing matches.
  function automatic logic [CharW-1:0] morse_lookup(input logic [PatW-1:0]     bits,
                                                    input logic [MarkCntW-1:0] count);
    logic [CharW-1:0] code;
    code = CharSpace;
    for (int t = 0; t < TableLen; t++) begin
      if (MorseTable[t].len == count && MorseTable[t].pat == bits) begin
        code = MorseTable[t].chr;
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/morse_pulse_decoder.sv */
// Morse pulse decoder: times marks and gaps of a sampled line and emits decoded ASCII characters.
//
// The slave stream takes one sampled line level per tick in s_axis_tdata[0]; one transfer is
// one tick. The master stream carries a decoded character in m_axis_tdata[6:0]. A character
// ends when a mark reaches long_limit ticks or a gap exceeds gap_timeout ticks; it is then
// looked up and sent, or a space when no pattern matches, nothing is stored or too many
// marks were seen. Each tick is handled in the cycle it is transferred, and the character
// it completes appears on the master side in the following cycle, and a tick can be taken
// every cycle unless the master side stalls. The result register frees itself in the same cycle
// it is taken, so s_axis_tready only falls while a character waits and m_axis_tready is low.
// The configuration channel writes the four registers by index at any time it is valid and
// is always ready; writes are expected only while the decoder is idle, and unknown indexes
// are ignored. Reset returns the registers to their defaults, empties the mark store, starts
// in a gap with a zero tick count and clears any pending character.
`timescale 1ns / 1ps
`default_nettype none

module morse_pulse_decoder #(
  parameter int unsigned MAX_MARKS  = mpd_pkg::MaxMarksDef,
  parameter int unsigned COUNT_BITS = mpd_pkg::CountBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [0] pin_level
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [6:0] char_code
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mpd_pkg::CfgW-1:0]     cfg_data_i
);
  import mpd_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > CfgW) ? COUNT_BITS : CfgW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [MarkCntW-1:0] MarksFull = MarkCntW'(MAX_MARKS);
  localparam logic [MarkCntW-1:0] MarksOver = MarkCntW'(MAX_MARKS + 1);

  logic [CfgW-1:0] gap_timeout_q, short_limit_q, long_limit_q;
  logic            first_swap_q;

  logic                  in_mark_q, in_mark_d;
  logic [COUNT_BITS-1:0] tick_q, tick_d, tick_inc;
  logic [MAX_MARKS-1:0]  mark_bits_q, mark_bits_d;
  logic [MarkCntW-1:0]   mark_count_q, mark_count_d;

  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_code_q, out_code_d;

  logic             s_accept;
  logic             pin;
  logic             finish;
  logic             store;
  logic             dash;
  logic             swap;
  logic [7:0]       bits_ext;
  logic [CharW-1:0] char_code;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign pin           = s_axis_tdata[0];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_code_q};

  assign tick_inc = (tick_q == CountMax) ? tick_q : tick_q + 1'b1;
  assign swap     = (mark_count_q == '0) && first_swap_q;
  assign bits_ext = 8'(mark_bits_q);

  always_comb begin
    if (mark_count_q == '0 || mark_count_q > MarksFull) begin
      char_code = CharSpace;
    end else begin
      char_code = morse_lookup(bits_ext[PatW-1:0], mark_count_q);
    end
  end

  always_comb begin
    in_mark_d = in_mark_q;
    tick_d    = tick_q;
    finish    = 1'b0;
    store     = 1'b0;
    dash      = 1'b0;
    if (in_mark_q) begin
      if (pin) begin
        tick_d = tick_inc;
      end else begin
        in_mark_d = 1'b0;
        tick_d    = COUNT_BITS'(1);
        if (CmpW'(tick_q) < CmpW'(short_limit_q)) begin
          store = 1'b1;
          dash  = swap;
        end else if (CmpW'(tick_q) < CmpW'(long_limit_q)) begin
          store = 1'b1;
          dash  = !swap;
        end else begin
          finish = 1'b1;
        end
      end
    end else begin
      if (pin) begin
        in_mark_d = 1'b1;
        tick_d    = COUNT_BITS'(1);
      end else if (CmpW'(tick_inc) > CmpW'(gap_timeout_q)) begin
        tick_d = '0;
        finish = 1'b1;
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  always_comb begin
    mark_bits_d  = mark_bits_q;
    mark_count_d = mark_count_q;
    if (finish) begin
      mark_bits_d  = '0;
      mark_count_d = '0;
    end else if (store) begin
      if (mark_count_q < MarksFull) begin
        for (int i = 0; i < MAX_MARKS; i++) begin
          if (dash && mark_count_q == MarkCntW'(i)) begin
            mark_bits_d[i] = 1'b1;
          end
        end
        mark_count_d = mark_count_q + 1'b1;
      end else begin
        mark_count_d = MarksOver;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    if (s_accept && finish) begin
      out_valid_d = 1'b1;
      out_code_d  = char_code;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_timeout_q <= GapTimeoutRst;
      short_limit_q <= ShortLimitRst;
      long_limit_q  <= LongLimitRst;
      first_swap_q  <= FirstSwapRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGapTimeout:    gap_timeout_q <= cfg_data_i;
        CfgShortLimit:    short_limit_q <= cfg_data_i;
        CfgLongLimit:     long_limit_q  <= cfg_data_i;
        CfgFirstMarkSwap: first_swap_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_mark_q    <= 1'b0;
      tick_q       <= '0;
      mark_bits_q  <= '0;
      mark_count_q <= '0;
    end else if (s_accept) begin
      in_mark_q    <= in_mark_d;
      tick_q       <= tick_d;
      mark_bits_q  <= mark_bits_d;
      mark_count_q <= mark_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_code_q <= out_code_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_count_q <= MarksOver)
    else $error("mark count beyond its saturation value");

  a_empty_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_count_q == '0 |-> mark_bits_q == '0)
    else $error("dash bits held with an empty mark store");

  a_mark_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_mark_q |-> tick_q != '0)
    else $error("mark being timed with a zero tick count");

  a_mark_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && !in_mark_q && pin |=> in_mark_q && tick_q == COUNT_BITS'(1))
    else $error("rising level did not start a mark");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s_accept))
    else $error("character raised without a tick transfer");

endmodule

`default_nettype wire

/* bench/morse_pulse_decoder_tb.sv */
// Self-checking testbench for the Morse pulse decoder: line ticks in, predicted characters compared.
`timescale 1ns / 1ps

module morse_pulse_decoder_tb;
  import mpd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 4'hF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  morse_pulse_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] pin_level
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [6:0] char_code
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  string morse_pats [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };
  string morse_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

  logic [CfgW-1:0] gap_limit = GapTimeoutRst;
  logic [CfgW-1:0] dot_limit = ShortLimitRst;
  logic [CfgW-1:0] dash_limit = LongLimitRst;
  logic swap_first = FirstSwapRst;

  logic mark_open = 1'b0;
  logic [CountBitsDef-1:0] run_ticks = '0;
  logic [PatW-1:0] dash_bits = '0;
  logic [MarkCntW-1:0] mark_total = '0;

  logic line_levels [$];
  logic [CharW-1:0] pending_chars [$];
  bit tick_taken = 1'b0;
  bit steady = 1'b0;
  int ticks_queued = 0;
  int ticks_done = 0;
  int chars_checked = 0;
  int reg_writes = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [CharW-1:0] char_for(logic [PatW-1:0] bits,
                                                logic [MarkCntW-1:0] count);
    logic [PatW-1:0] pat;
    string p;
    byte g;
    for (int t = 0; t < 36; t++) begin
      p = morse_pats[t];
      pat = '0;
      for (int k = 0; k < p.len(); k++) begin
        if (p[k] == "-") pat[k] = 1'b1;
      end
      if (p.len() == count && pat == bits) begin
        g = morse_glyphs[t];
        return g[CharW-1:0];
      end
    end
    return CharSpace;
  endfunction

  task automatic close_char(output logic [CharW-1:0] code);
    code = char_for(dash_bits, mark_total);
    dash_bits = '0;
    mark_total = '0;
  endtask

  task automatic store_mark(input bit dash);
    if (mark_total < MaxMarksDef) begin
      if (dash) dash_bits[mark_total] = 1'b1;
      mark_total = mark_total + 1'b1;
    end else begin
      mark_total = MarkCntW'(MaxMarksDef + 1);
    end
  endtask

  task automatic decode_tick(input logic pin, output bit emit, output logic [CharW-1:0] code);
    logic [CountBitsDef-1:0] dur;
    bit swp;
    emit = 1'b0;
    code = CharSpace;
    if (mark_open) begin
      if (pin) begin
        if (run_ticks != '1) run_ticks = run_ticks + 1'b1;
      end else begin
        mark_open = 1'b0;
        dur = run_ticks;
        swp = (mark_total == 0) && swap_first;
        run_ticks = CountBitsDef'(1);
        if (dur < dot_limit) begin
          store_mark(swp);
        end else if (dur < dash_limit) begin
          store_mark(!swp);
        end else begin
          emit = 1'b1;
          close_char(code);
        end
      end
    end else if (pin) begin
      mark_open = 1'b1;
      run_ticks = CountBitsDef'(1);
    end else begin
      if (run_ticks != '1) run_ticks = run_ticks + 1'b1;
      if (run_ticks > gap_limit) begin
        run_ticks = '0;
        emit = 1'b1;
        close_char(code);
      end
    end
  endtask

  // Driver: a new tick is offered once the previous transfer has completed.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || tick_taken) begin
        if (line_levels.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
          s_axis_tdata <= {7'd0, line_levels.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk_i) begin : monitor
    bit emit;
    logic [CharW-1:0] code;
    logic [CharW-1:0] want;
    cycles++;
    tick_taken = s_axis_tvalid && s_axis_tready;
    if (tick_taken) begin
      ticks_done++;
      decode_tick(s_axis_tdata[0], emit, code);
      if (emit) pending_chars.insert(pending_chars.size(), code);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      reg_writes++;
      case (cfg_index_i)
        CfgGapTimeout:    gap_limit = cfg_data_i;
        CfgShortLimit:    dot_limit = cfg_data_i;
        CfgLongLimit:     dash_limit = cfg_data_i;
        CfgFirstMarkSwap: swap_first = cfg_data_i[0];
        default: ;
      endcase
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected character %0d at cycle %0d", m_axis_tdata[6:0], cycles);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata[6:0] !== want) begin
          errors++;
          if (errors <= 10)
            $display("character mismatch at cycle %0d: expected %0d, got %0d",
                     cycles, want, m_axis_tdata[6:0]);
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("timed out after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_levels(input logic lvl, input int n);
    repeat (n) line_levels.insert(line_levels.size(), lvl);
    ticks_queued += n;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (line_levels.size() != 0 || (s_axis_tvalid && !tick_taken) || pending_chars.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] gap, dot, dash, swap_word);
    wait_drained();
    write_reg(CfgNoReg, 16'hFFFF);
    write_reg(CfgGapTimeout, gap);
    write_reg(CfgShortLimit, dot);
    write_reg(CfgLongLimit, dash);
    write_reg(CfgFirstMarkSwap, swap_word);
    cfg_valid_i <= 1'b0;
  endtask

  // One character with random marks, ended by a long gap or by an over-long mark.
  task automatic random_char();
    int n, lo, hi, g;
    bit can_dot, can_dash;
    can_dot = dot_limit > 1;
    can_dash = dash_limit > dot_limit;
    g = (gap_limit > 8) ? 8 : gap_limit;
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5, 1);
    for (int i = 0; i < n; i++) begin
      if (can_dash && (!can_dot || $urandom_range(1) == 1)) begin
        lo = dot_limit;
        hi = (dash_limit - 1 > dot_limit + 6) ? dot_limit + 6 : dash_limit - 1;
      end else if (can_dot) begin
        lo = 1;
        hi = (dot_limit - 1 > 8) ? 8 : dot_limit - 1;
      end else begin
        lo = dash_limit;
        hi = dash_limit + 2;
      end
      push_levels(1'b1, $urandom_range(hi, lo));
      if (i != n - 1) push_levels(1'b0, $urandom_range(g, 1));
    end
    if (dash_limit <= 16 && $urandom_range(4) == 0) begin
      lo = (dash_limit > dot_limit) ? dash_limit : dot_limit;
      push_levels(1'b0, $urandom_range(g, 1));
      push_levels(1'b1, $urandom_range(lo + 3, lo));
      push_levels(1'b0, 1);
    end else begin
      push_levels(1'b0, gap_limit + 1 + $urandom_range(2));
    end
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = ticks_queued;
    while (ticks_queued - start < budget) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(12, 1)) push_levels(1'($urandom_range(1)), 1);
      end else begin
        random_char();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: a first short mark read as a dash, ended by an over-long mark.
    push_levels(1'b0, 5);
    push_levels(1'b1, 50);
    push_levels(1'b0, 5);
    push_levels(1'b1, 200);
    push_levels(1'b0, 1);

    configure(16'd4, 16'd3, 16'd6, 16'd1);
    push_levels(1'b0, 5);
    push_levels(1'b1, 1);
    push_levels(1'b0, 1);
    push_levels(1'b1, 4);
    push_levels(1'b0, 5);
    repeat (6) begin
      push_levels(1'b1, 1);
      push_levels(1'b0, 1);
    end
    push_levels(1'b0, 4);
    push_levels(1'b1, 2);
    push_levels(1'b0, 1);
    push_levels(1'b1, 7);
    push_levels(1'b0, 6);

    configure(16'd6, 16'd3, 16'd7, 16'd1);
    random_phase(450);
    steady = 1'b1;
    configure(16'd5, 16'd2, 16'd5, 16'hFFFE);
    random_phase(180);
    steady = 1'b0;
    configure(16'd4, 16'd5, 16'd3, 16'd1);
    random_phase(150);
    configure(16'd1, 16'd1, 16'd1, 16'd0);
    random_phase(60);
    configure(16'd3, 16'hFFFF, 16'hFFFF, 16'd1);
    random_phase(100);

    configure(16'd3, 16'd2, 16'd4, 16'd0);
    push_levels(1'b0, 5);
    random_phase(40);

    wait_drained();
    repeat (8) @(negedge clk_i);
    $display("covered %0d line ticks and %0d register writes over eight settings,",
             ticks_done, reg_writes);
    $display("with %0d decoded characters checked and %0d mismatches", chars_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
